// ----- design/pal_pkg.sv -----
// Shared types and constants for the positional array list unit.
// No dependencies; imported by every module of the block.
package pal_pkg;

  localparam int DEPTH  = 64;
  localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int POS_W  = 8;
  localparam int CAP_W  = 7;
  localparam int WORD_W = 32;
  localparam int CMP_W  = 10;
  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(64);

  typedef enum logic [1:0] {
    OP_READ   = 2'd0,
    OP_INSERT = 2'd1,
    OP_REMOVE = 2'd2
  } op_t;

  typedef struct packed {
    logic [1:0]              op;
    logic [POS_W-1:0]        position;
    logic signed [WORD_W-1:0] new_value;
  } in_item_t;

  typedef struct packed {
    logic signed [WORD_W-1:0] value_out;
    logic                     ok;
    logic [6:0]               count_out;
    logic                     is_empty;
    logic                     is_full;
  } out_item_t;

  // Broadcast to every cell in the row for one transaction.
  typedef struct packed {
    logic                     ins;
    logic                     rem;
    logic [POS_W-1:0]         pos_m1;
    logic signed [WORD_W-1:0] new_value;
  } cell_cmd_t;

endpackage

// ----- design/pal_cell.sv -----
// One storage cell of the list: holds a word, shifts to/from its neighbors.
// Depends on pal_pkg.
module pal_cell import pal_pkg::*; (
  input  logic                     clk,
  input  logic [IDX_W-1:0]         idx,
  input  cell_cmd_t                cmd,
  input  logic signed [WORD_W-1:0] lower_val,
  input  logic signed [WORD_W-1:0] upper_val,
  output logic signed [WORD_W-1:0] val,
  output logic signed [WORD_W-1:0] rd_val
);

  logic signed [WORD_W-1:0] val_r;
  logic signed [WORD_W-1:0] val_nxt;
  logic [POS_W:0]           my_idx;
  logic [POS_W:0]           pos;
  logic                     hit;
  logic                     above;

  assign my_idx = (POS_W + 1)'(idx);
  assign pos    = {1'b0, cmd.pos_m1};
  assign hit    = (my_idx == pos);
  assign above  = (my_idx > pos);

  always_comb begin
    val_nxt = val_r;
    if (cmd.ins) begin
      if (above) begin
        val_nxt = lower_val;
      end else if (hit) begin
        val_nxt = cmd.new_value;
      end
    end else if (cmd.rem) begin
      if (above || hit) begin
        val_nxt = upper_val;
      end
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

  assign val    = val_r;
  assign rd_val = hit ? val_r : '0;

endmodule

// ----- design/pal_cell_row.sv -----
// Row of DEPTH list cells with neighbor links and the selected-word readout.
// Depends on pal_pkg and pal_cell.
module pal_cell_row import pal_pkg::*; (
  input  logic                     clk,
  input  cell_cmd_t                cmd,
  output logic signed [WORD_W-1:0] rd_word
);

  logic signed [WORD_W-1:0] vals [DEPTH];
  logic signed [WORD_W-1:0] rds  [DEPTH];

  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    logic signed [WORD_W-1:0] lower;
    logic signed [WORD_W-1:0] upper;
    if (k == 0) begin : g_first
      assign lower = '0;
    end else begin : g_mid_lo
      assign lower = vals[k-1];
    end
    if (k == DEPTH - 1) begin : g_last
      assign upper = vals[k];
    end else begin : g_mid_hi
      assign upper = vals[k+1];
    end
    pal_cell u_cell (
      .clk       (clk),
      .idx       (IDX_W'(k)),
      .cmd       (cmd),
      .lower_val (lower),
      .upper_val (upper),
      .val       (vals[k]),
      .rd_val    (rds[k])
    );
  end

  always_comb begin
    rd_word = '0;
    for (int k = 0; k < DEPTH; k++) begin
      rd_word = rd_word | rds[k];
    end
  end

endmodule

// ----- design/positional_array_list_unit.sv -----
// Top level of the positional array list unit: control, count, output register.
// Depends on pal_pkg and pal_cell_row.
//
// Usage:
//   in_*  : one transaction per operation (read, insert or remove at a
//           1-based position; new_value used by insert only).
//   out_* : one transaction per accepted operation, in order, carrying the
//           word read or removed (-1 on failure or insert), ok, the count
//           after the operation, and empty/full flags.
//   cfg_* : writes the capacity register (reset 64, limited to the depth).
//           Always ready; write only while no transaction is in flight.
// The result is registered in the cycle after the input transaction.
// Throughput: one operation per cycle unless stalled. All DEPTH cells compare
//   their index with the position and shift in parallel in the accepting
//   cycle; the selected word comes out through a single OR readout of the row.
// Reset: count cleared, capacity set to 64, output register empty. Cell
//   contents are not cleared; positions are valid only once written.
// Stall: when out_ready is low the result holds in the output register and
//   in_ready drops until it is taken.
module positional_array_list_unit import pal_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  in_item_t         in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output out_item_t        out_data,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [CAP_W-1:0] cfg_wdata
);

  logic [CNT_W-1:0]         count_r;
  logic [CNT_W-1:0]         count_nxt;
  logic [CAP_W-1:0]         cap_r;
  logic                     out_valid_r;
  out_item_t                out_r;
  out_item_t                out_nxt;
  cell_cmd_t                cmd;
  logic signed [WORD_W-1:0] rd_word;
  logic                     acc;
  logic [CMP_W-1:0]         cnt_w;
  logic [CMP_W-1:0]         cnt_nxt_w;
  logic [CMP_W-1:0]         cap_w;
  logic [CMP_W-1:0]         eff_cap;
  logic [CMP_W-1:0]         pos_w;
  logic                     pos_nz;
  logic                     rd_ok;
  logic                     ins_ok;
  logic                     ok;

  assign in_ready  = !out_valid_r || out_ready;
  assign acc       = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  assign cnt_w   = CMP_W'(count_r);
  assign cap_w   = CMP_W'(cap_r);
  assign eff_cap = (cap_w > CMP_W'(DEPTH)) ? CMP_W'(DEPTH) : cap_w;
  assign pos_w   = CMP_W'(in_data.position);
  assign pos_nz  = (in_data.position != '0);
  assign rd_ok   = pos_nz && (pos_w <= cnt_w);
  assign ins_ok  = pos_nz && (cnt_w < eff_cap) && (pos_w <= cnt_w + CMP_W'(1));

  always_comb begin
    case (in_data.op)
      OP_READ:   ok = rd_ok;
      OP_INSERT: ok = ins_ok;
      OP_REMOVE: ok = rd_ok;
      default:   ok = 1'b0;
    endcase
  end

  always_comb begin
    cmd.ins       = acc && ok && (in_data.op == OP_INSERT);
    cmd.rem       = acc && ok && (in_data.op == OP_REMOVE);
    cmd.pos_m1    = in_data.position - POS_W'(1);
    cmd.new_value = in_data.new_value;
  end

  pal_cell_row u_row (
    .clk     (clk),
    .cmd     (cmd),
    .rd_word (rd_word)
  );

  always_comb begin
    count_nxt = count_r;
    if (cmd.ins) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (cmd.rem) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  assign cnt_nxt_w = CMP_W'(count_nxt);

  always_comb begin
    out_nxt.value_out = ok && (in_data.op != OP_INSERT) ? rd_word : -32'sd1;
    out_nxt.ok        = ok;
    out_nxt.count_out = 7'(count_nxt);
    out_nxt.is_empty  = (count_nxt == '0);
    out_nxt.is_full   = (cnt_nxt_w >= eff_cap);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      cap_r       <= CAP_RESET;
      out_valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (cfg_valid && cfg_ready) begin
        cap_r <= cfg_wdata;
      end
      if (acc) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// ----- design/pal_checker.sv -----
// Port-level checks for positional_array_list_unit, attached by bind.
// Depends on pal_pkg.
module pal_checker import pal_pkg::*; (
  input logic             clk,
  input logic             rst_n,
  input logic             in_valid,
  input logic             in_ready,
  input logic             out_valid,
  input logic             out_ready,
  input out_item_t        out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  a_in_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> out_valid)
    else $error("accepted transaction gave no result");

  a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.is_empty == (out_data.count_out == '0))
    else $error("empty flag disagrees with count");

  a_fail_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.ok |-> out_data.value_out == -32'sd1)
    else $error("rejected transaction returned a word");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> 32'(out_data.count_out) <= DEPTH)
    else $error("count beyond storage depth");

endmodule

bind positional_array_list_unit pal_checker u_pal_checker (.*);
